### rtl/pwmf_pkg.sv
package pwmf_pkg;

  // Per-buffer status; unknown_seen and stopped are sticky, hs_match is re-armed after each known message.
  typedef struct packed {
    logic hs_match;
    logic unknown_seen;
    logic stopped;
  } pwmf_flags_t;

  localparam int HANDSHAKE_BYTES = 68;
  localparam int PREFIX_BYTES    = 20;
  localparam int PREFIX_LEN_BYTES = 4;

  localparam logic [7:0] ID_NOT_INTERESTED = 8'd3;
  localparam logic [7:0] ID_HAVE           = 8'd4;
  localparam logic [7:0] ID_BITFIELD       = 8'd5;
  localparam logic [7:0] ID_REQUEST        = 8'd6;
  localparam logic [7:0] ID_PIECE          = 8'd7;
  localparam logic [7:0] ID_CANCEL         = 8'd8;
  localparam logic [7:0] ID_PORT           = 8'd9;

  localparam logic [31:0] LEN_KEEPALIVE = 32'd0;
  localparam logic [31:0] LEN_STATE     = 32'd1;
  localparam logic [31:0] LEN_PORT      = 32'd3;
  localparam logic [31:0] LEN_HAVE      = 32'd5;
  localparam logic [31:0] LEN_REQUEST   = 32'd13;

  localparam pwmf_flags_t FLAGS_RESET = '{hs_match: 1'b1, unknown_seen: 1'b0, stopped: 1'b0};

  // Handshake prefix: pstrlen 19 then the protocol string.
  function automatic logic [7:0] hs_prefix(input logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      5'd0:  ch = 8'h13;
      5'd1:  ch = 8'h42; // B
      5'd2:  ch = 8'h69; // i
      5'd3:  ch = 8'h74; // t
      5'd4:  ch = 8'h54; // T
      5'd5:  ch = 8'h6f; // o
      5'd6:  ch = 8'h72; // r
      5'd7:  ch = 8'h72; // r
      5'd8:  ch = 8'h65; // e
      5'd9:  ch = 8'h6e; // n
      5'd10: ch = 8'h74; // t
      5'd11: ch = 8'h20; // space
      5'd12: ch = 8'h70; // p
      5'd13: ch = 8'h72; // r
      5'd14: ch = 8'h6f; // o
      5'd15: ch = 8'h74; // t
      5'd16: ch = 8'h6f; // o
      5'd17: ch = 8'h63; // c
      5'd18: ch = 8'h6f; // o
      5'd19: ch = 8'h6c; // l
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_known(input logic [31:0] len, input logic [7:0] id);
    logic ok;
    ok = (len == LEN_KEEPALIVE)
      || (id == ID_BITFIELD) || (id == ID_PIECE)
      || ((len == LEN_STATE) && (id <= ID_NOT_INTERESTED))
      || ((len == LEN_HAVE) && (id == ID_HAVE))
      || ((len == LEN_REQUEST) && ((id == ID_REQUEST) || (id == ID_CANCEL)))
      || ((len == LEN_PORT) && (id == ID_PORT));
    return ok;
  endfunction

endpackage

### rtl/pwmf_parse.sv
// Next-state logic for one buffer byte.
module pwmf_parse #(
  parameter int BUFFER_BYTES = 65536
) (
  input  logic [7:0]                           data_byte,
  input  logic [$clog2(BUFFER_BYTES+1)-1:0]    pos,
  input  logic [$clog2(BUFFER_BYTES+1)-1:0]    committed,
  input  logic [$clog2(BUFFER_BYTES+1)-1:0]    count,
  input  logic [31:0]                          len,
  input  logic [7:0]                           id,
  input  pwmf_pkg::pwmf_flags_t                flags,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]    pos_nxt,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]    committed_nxt,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]    count_nxt,
  output logic [31:0]                          len_nxt,
  output logic [7:0]                           id_nxt,
  output pwmf_pkg::pwmf_flags_t                flags_nxt,
  output logic                                 all_complete,
  output logic [16:0]                          complete_length
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);

  logic          take;
  logic [31:0]   len_t;
  logic [7:0]    id_t;
  logic          match_t;
  logic [PW-1:0] pos_t;
  logic [PW-1:0] k;
  logic          done;
  logic          known;

  always_comb begin
    take    = !flags.stopped && (pos < PW'(BUFFER_BYTES));
    len_t   = (count < PW'(pwmf_pkg::PREFIX_LEN_BYTES)) ? {len[23:0], data_byte} : len;
    id_t    = (count == PW'(pwmf_pkg::PREFIX_LEN_BYTES)) ? data_byte : id;
    match_t = flags.hs_match &&
              !((count < PW'(pwmf_pkg::PREFIX_BYTES)) &&
                (data_byte != pwmf_pkg::hs_prefix(count[4:0])));
    pos_t   = pos + PW'(1);
    k       = count + PW'(1);
    if (match_t) begin
      done = (k == PW'(pwmf_pkg::HANDSHAKE_BYTES));
    end else begin
      done = (k >= PW'(pwmf_pkg::PREFIX_LEN_BYTES)) &&
             (33'(k) == ({1'b0, len_t} + 33'd4));
    end
    // handshake counts as known whenever its prefix matched
    known = match_t || pwmf_pkg::is_known(len_t, id_t);

    pos_nxt       = pos;
    committed_nxt = committed;
    count_nxt     = count;
    len_nxt       = len;
    id_nxt        = id;
    flags_nxt     = flags;
    if (take) begin
      pos_nxt            = pos_t;
      count_nxt          = k;
      len_nxt            = len_t;
      id_nxt             = id_t;
      flags_nxt.hs_match = match_t;
      if (done) begin
        committed_nxt = pos_t;
        if (known) begin
          count_nxt          = '0;
          len_nxt            = '0;
          id_nxt             = '0;
          flags_nxt.hs_match = 1'b1;
        end else begin
          flags_nxt.unknown_seen = 1'b1;
          flags_nxt.stopped      = 1'b1;
        end
      end
    end

    all_complete    = !flags_nxt.stopped && !flags_nxt.unknown_seen && (count_nxt == '0);
    complete_length = 17'(committed_nxt);
  end

endmodule

### rtl/peer_wire_message_framer_core.sv
// A request carrying last_byte passes through the input register, then the result register, to its result.
// Throughput: one byte per cycle; in_stall rises only while a finished result is held
//   and a next last byte waits behind it.
// Reset: synchronous, active low; clears the valid bits of both pipeline registers and the framing state.
// Framing state returns to its reset value after each buffer's result.
module peer_wire_message_framer_core #(
  parameter int BUFFER_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_all_complete,
  output logic [16:0] out_complete_length
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] data_r;
  logic       last_r;

  // framing state
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [PW-1:0]         committed_r, committed_nxt;
  logic [PW-1:0]         count_r, count_nxt;
  logic [31:0]           len_r, len_nxt;
  logic [7:0]            id_r, id_nxt;
  pwmf_pkg::pwmf_flags_t flags_r, flags_nxt;

  // parse outputs
  logic [PW-1:0]         p_pos, p_committed, p_count;
  logic [31:0]           p_len;
  logic [7:0]            p_id;
  pwmf_pkg::pwmf_flags_t p_flags;
  logic                  p_all_complete;
  logic [16:0]           p_complete_length;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        all_complete_r;
  logic [16:0] complete_length_r;

  logic in_take;
  logic proc_go;

  pwmf_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .data_byte      (data_r),
    .pos            (pos_r),
    .committed      (committed_r),
    .count          (count_r),
    .len            (len_r),
    .id             (id_r),
    .flags          (flags_r),
    .pos_nxt        (p_pos),
    .committed_nxt  (p_committed),
    .count_nxt      (p_count),
    .len_nxt        (p_len),
    .id_nxt         (p_id),
    .flags_nxt      (p_flags),
    .all_complete   (p_all_complete),
    .complete_length(p_complete_length)
  );

  // A byte that ends the buffer needs the result register free (or draining).
  always_comb begin
    proc_go  = in_valid_r && (!last_r || !out_valid_r || !out_stall);
    in_stall = in_valid_r && !proc_go;
    in_take  = in_valid && !in_stall;
  end

  always_comb begin
    in_valid_nxt = in_take || (in_valid_r && !proc_go);

    pos_nxt       = pos_r;
    committed_nxt = committed_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    id_nxt        = id_r;
    flags_nxt     = flags_r;
    if (proc_go) begin
      if (last_r) begin
        // buffer done: back to the start-of-buffer state
        pos_nxt       = '0;
        committed_nxt = '0;
        count_nxt     = '0;
        len_nxt       = '0;
        id_nxt        = '0;
        flags_nxt     = pwmf_pkg::FLAGS_RESET;
      end else begin
        pos_nxt       = p_pos;
        committed_nxt = p_committed;
        count_nxt     = p_count;
        len_nxt       = p_len;
        id_nxt        = p_id;
        flags_nxt     = p_flags;
      end
    end

    if (proc_go && last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      committed_r <= '0;
      count_r     <= '0;
      len_r       <= '0;
      id_r        <= '0;
      flags_r     <= pwmf_pkg::FLAGS_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      committed_r <= committed_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      id_r        <= id_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (proc_go && last_r) begin
      all_complete_r    <= p_all_complete;
      complete_length_r <= p_complete_length;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_all_complete    = all_complete_r;
  assign out_complete_length = complete_length_r;

endmodule

### rtl/pwmf_checker.sv
module pwmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_all_complete,
  input logic [16:0] out_complete_length
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_all_complete)
                               && $stable(out_complete_length))
    else $error("result changed while stalled");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  // no stall toward the source when nothing waits to be taken
  a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind peer_wire_message_framer_core pwmf_checker u_pwmf_checker (.*);
